[hdl/isq_pkg.sv]
`timescale 1ns / 1ps

package isq_pkg;

  // field widths fixed by the interface
  localparam int unsigned WordW = 32;
  localparam int unsigned CntW  = 8;

  // operation codes
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;
  localparam logic [1:0] OP_INSERT = 2'd3;

  // one command word
  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [WordW-1:0] value;
    logic [CntW-1:0]         position;
  } isq_in_t;

  // one result word
  typedef struct packed {
    logic                    ok;
    logic signed [WordW-1:0] data;
    logic [CntW-1:0]         count;
    logic                    full_res;
    logic                    empty_res;
  } isq_out_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                    wr_en;    // push or insert taking effect
    logic                    pop_en;   // pop taking effect
    logic [CntW-1:0]         ins_pos;  // slot that takes the new word
    logic signed [WordW-1:0] value;
  } isq_cell_ctl_t;

endpackage

[hdl/insertable_shift_queue.sv]
`timescale 1ns / 1ps

// Queue of signed 32-bit words held in a chain of cells, head in cell 0.
// Commands push, pop, peek and insert-at-position; an insert position at or
// past the fill appends. One command is taken every clock (busy_o stays
// low): every cell loads, moves back or moves forward in the same cycle.
// The result word appears on result_o with valid_o high in the cycle after
// start_i, for exactly one cycle, and there is no way to hold it; a receiver
// must take it then. Storage words are not cleared at reset and need no
// clearing pass, since only stored entries are ever read.
module insertable_shift_queue #(
  parameter int unsigned DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  isq_pkg::isq_in_t   in_i,
  output logic               valid_o,
  output isq_pkg::isq_out_t  result_o
);
  import isq_pkg::*;

  isq_cell_ctl_t           cell_ctl;
  logic signed [WordW-1:0] cell_q [DEPTH];

  // commands never wait
  assign busy_o = 1'b0;

  // fill count, command decode and result register
  isq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .in_i     (in_i),
    .head_i   (cell_q[0]),
    .ctl_o    (cell_ctl),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  // chain of storage cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WordW-1:0] prev_w, next_w;
    if (g == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid
      assign prev_w = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_w = cell_q[g];
    end else begin : g_body
      assign next_w = cell_q[g+1];
    end
    isq_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl),
      .prev_i (prev_w),
      .next_i (next_w),
      .q_o    (cell_q[g])
    );
  end

endmodule

[hdl/isq_cell.sv]
`timescale 1ns / 1ps

module isq_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                         clk_i,
  input  isq_pkg::isq_cell_ctl_t       ctl_i,
  input  logic signed [isq_pkg::WordW-1:0] prev_i,
  input  logic signed [isq_pkg::WordW-1:0] next_i,
  output logic signed [isq_pkg::WordW-1:0] q_o
);
  import isq_pkg::*;

  localparam logic [CntW-1:0] MyIdx = CntW'(IDX);

  logic signed [WordW-1:0] word_q, word_d;

  // load, move back from the previous cell, or move forward from the next one
  always_comb begin
    word_d = word_q;
    if (ctl_i.pop_en) begin
      word_d = next_i;
    end else if (ctl_i.wr_en) begin
      if (MyIdx == ctl_i.ins_pos) begin
        word_d = ctl_i.value;
      end else if (MyIdx > ctl_i.ins_pos) begin
        word_d = prev_i;
      end
    end
  end

  // storage word, no reset needed
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign q_o = word_q;

endmodule

[hdl/isq_ctrl.sv]
`timescale 1ns / 1ps

module isq_ctrl #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  isq_pkg::isq_in_t                 in_i,
  input  logic signed [isq_pkg::WordW-1:0] head_i,
  output isq_pkg::isq_cell_ctl_t           ctl_o,
  output logic                             valid_o,
  output isq_pkg::isq_out_t                result_o
);
  import isq_pkg::*;

  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  logic [CntW-1:0] count_q, count_d;
  logic            valid_q;
  isq_out_t        res_q, res_d;
  logic            full, empty;
  logic            do_wr, do_pop, do_read;

  assign full  = (count_q == DepthC);
  assign empty = (count_q == '0);

  // decode the command against the current fill
  always_comb begin
    do_wr   = 1'b0;
    do_pop  = 1'b0;
    do_read = 1'b0;
    case (in_i.opcode)
      OP_PUSH, OP_INSERT: do_wr = start_i && !full;
      OP_POP: begin
        do_pop  = start_i && !empty;
        do_read = do_pop;
      end
      OP_PEEK: do_read = start_i && !empty;
      default: ;
    endcase
  end

  // broadcast to the cells; push and an insert past the tail both append
  always_comb begin
    ctl_o.wr_en  = do_wr;
    ctl_o.pop_en = do_pop;
    ctl_o.value  = in_i.value;
    if (in_i.opcode == OP_PUSH || in_i.position >= count_q) begin
      ctl_o.ins_pos = count_q;
    end else begin
      ctl_o.ins_pos = in_i.position;
    end
  end

  // next fill and result word
  always_comb begin
    count_d = count_q;
    if (do_wr) begin
      count_d = count_q + 1'b1;
    end else if (do_pop) begin
      count_d = count_q - 1'b1;
    end
    res_d.ok        = do_wr || do_read;
    res_d.data      = do_read ? head_i : '0;
    res_d.count     = count_d;
    res_d.full_res  = (count_d == DepthC);
    res_d.empty_res = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= start_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

  // fill never exceeds the depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("fill count beyond depth");

  // every command gives exactly one word on the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> valid_o)
    else $error("missing result word");

  // fill only moves when a command is taken
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |=> $stable(count_q))
    else $error("fill changed without a command");

  // reported count matches the stored fill
  a_count_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> result_o.count == count_q)
    else $error("reported count differs from fill");

  // a refused command leaves no data
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !result_o.ok |-> result_o.data == '0)
    else $error("refused command returned data");

endmodule
